// ===== src/knob_step_accelerator_zero_detent_unit_macros.svh =====
// Assertion macros shared by the knob step accelerator RTL.
`ifndef KNOB_STEP_ACCELERATOR_ZERO_DETENT_UNIT_MACROS_SVH
`define KNOB_STEP_ACCELERATOR_ZERO_DETENT_UNIT_MACROS_SVH

// Checked on every rising edge of clk, ignored while arst_n is low.
`define KSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define KSA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ksa_pkg.sv =====
// Package with types, constants and register codes of the knob step accelerator.
`timescale 1ns / 1ps
`default_nettype none
package ksa_pkg;

	localparam int NUM_KNOBS_DEF      = 8;
	localparam int NUM_HOLD_SLOTS_DEF = 4;

	localparam logic [31:0] ACCEL_T1 = 32'd75;
	localparam logic [31:0] ACCEL_T2 = 32'd50;
	localparam logic [31:0] ACCEL_T3 = 32'd25;

	localparam logic [15:0]        HOLD_MS_RST = 16'd500;
	localparam logic signed [15:0] ZERO_PT_RST = 16'sd500;

	localparam int APB_AW = 4;

	localparam logic [1:0] REG_HOLD_MS  = 2'd0;
	localparam logic [1:0] REG_SHIFT_ZP = 2'd1;
	localparam logic [1:0] REG_TRIG_ZP  = 2'd2;

	localparam logic [1:0] ZSEL_SHIFT   = 2'd0;
	localparam logic [1:0] ZSEL_TRIG    = 2'd1;
	localparam logic [1:0] ZSEL_LITERAL = 2'd2;
	localparam logic [1:0] ZSEL_SPARE   = 2'd3;

	typedef struct packed {
		logic [15:0]        hold_ms;
		logic signed [15:0] shift_zero_point;
		logic signed [15:0] trigger_zero_point;
	} ksa_cfg_t;

	typedef struct packed {
		logic [2:0]         knob_index;
		logic [1:0]         hold_slot;
		logic [1:0]         zero_select;
		logic signed [7:0]  rel_step;
		logic signed [15:0] current_value;
		logic [31:0]        now_ms;
	} ksa_item_t;

	typedef struct packed {
		logic signed [15:0] new_value;
		logic               accepted;
	} ksa_result_t;

endpackage
`default_nettype wire

// ===== src/ksa_if.sv =====
// Stream interfaces for knob events and their results.
`timescale 1ns / 1ps
`default_nettype none
interface ksa_evt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         knob_index;
	logic [1:0]         hold_slot;
	logic [1:0]         zero_select;
	logic signed [7:0]  rel_step;
	logic signed [15:0] current_value;
	logic [31:0]        now_ms;

	modport source (output valid, knob_index, hold_slot, zero_select, rel_step,
		current_value, now_ms, input ready);
	modport sink (input valid, knob_index, hold_slot, zero_select, rel_step,
		current_value, now_ms, output ready);
endinterface

interface ksa_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] new_value;
	logic               accepted;

	modport source (output valid, new_value, accepted, input ready);
	modport sink (input valid, new_value, accepted, output ready);
endinterface
`default_nettype wire

// ===== src/ksa_apb_regs.sv =====
// APB configuration registers of the knob step accelerator.
`timescale 1ns / 1ps
`default_nettype none
module ksa_apb_regs
	import ksa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output ksa_cfg_t               cfg
);

	ksa_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms            <= HOLD_MS_RST;
			cfg_q.shift_zero_point   <= ZERO_PT_RST;
			cfg_q.trigger_zero_point <= ZERO_PT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HOLD_MS:  cfg_q.hold_ms            <= pwdata[15:0];
				REG_SHIFT_ZP: cfg_q.shift_zero_point   <= pwdata[15:0];
				REG_TRIG_ZP:  cfg_q.trigger_zero_point <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HOLD_MS:  prdata = {16'd0, cfg_q.hold_ms};
			REG_SHIFT_ZP: prdata = {{16{cfg_q.shift_zero_point[15]}}, cfg_q.shift_zero_point};
			REG_TRIG_ZP:  prdata = {{16{cfg_q.trigger_zero_point[15]}},
				cfg_q.trigger_zero_point};
			default:      prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/ksa_step_core.sv =====
// Acceleration, zero snap, saturation and hold logic with the per-knob and per-slot timers.
`timescale 1ns / 1ps
`default_nettype none
`include "knob_step_accelerator_zero_detent_unit_macros.svh"
module ksa_step_core
	import ksa_pkg::*;
#(
	parameter int NUM_KNOBS      = NUM_KNOBS_DEF,
	parameter int NUM_HOLD_SLOTS = NUM_HOLD_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ksa_cfg_t    cfg,
	input  wire ksa_item_t   item,
	input  wire logic        fire,
	output ksa_result_t      result
);

	localparam int KW = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
	localparam int SW = (NUM_HOLD_SLOTS > 1) ? $clog2(NUM_HOLD_SLOTS) : 1;

	logic [31:0]               last_q  [NUM_KNOBS];
	logic [31:0]               start_q [NUM_HOLD_SLOTS];
	logic [NUM_HOLD_SLOTS-1:0] active_q;

	logic [KW-1:0]      knob_sel;
	logic [SW-1:0]      slot_sel;
	logic [31:0]        delta;
	logic signed [10:0] rel_x;
	logic signed [10:0] step_acc;
	logic signed [10:0] step;
	logic signed [15:0] zero;
	logic signed [16:0] sum;
	logic signed [16:0] snapped;
	logic signed [15:0] nv;
	logic               hit_zero;
	logic [31:0]        elapsed;
	logic               expired;

	// Indexes wrap at the knob and slot counts through small tables of constants.
	always_comb begin
		knob_sel = '0;
		for (int i = 0; i < 8; i++) begin
			if (item.knob_index == 3'(i)) begin
				knob_sel = KW'(i % NUM_KNOBS);
			end
		end
	end

	always_comb begin
		slot_sel = '0;
		for (int i = 0; i < 4; i++) begin
			if (item.hold_slot == 2'(i)) begin
				slot_sel = SW'(i % NUM_HOLD_SLOTS);
			end
		end
	end

	assign delta    = item.now_ms - last_q[knob_sel];
	assign rel_x    = {{3{item.rel_step[7]}}, item.rel_step};

	always_comb begin
		if (delta > ACCEL_T1) begin
			step_acc = rel_x;
		end else if (delta > ACCEL_T2) begin
			step_acc = rel_x <<< 1;
		end else if (delta > ACCEL_T3) begin
			step_acc = rel_x + (rel_x <<< 1);
		end else begin
			step_acc = rel_x <<< 2;
		end
	end

	// Literal zero and the spare select force a nonzero step so the knob never stalls on it.
	always_comb begin
		step = step_acc;
		case (item.zero_select)
			ZSEL_SHIFT: zero = cfg.shift_zero_point;
			ZSEL_TRIG:  zero = cfg.trigger_zero_point;
			default: begin
				zero = 16'sd0;
				if (step_acc == 11'sd0) begin
					step = 11'sd1;
				end
			end
		endcase
	end

	assign sum = {item.current_value[15], item.current_value} + {{6{step[10]}}, step};

	always_comb begin
		if ((item.current_value > zero && sum < $signed({zero[15], zero})) ||
			(item.current_value < zero && sum > $signed({zero[15], zero}))) begin
			snapped = {zero[15], zero};
		end else begin
			snapped = sum;
		end
	end

	assign nv = (snapped[16] != snapped[15]) ? (snapped[16] ? 16'sh8000 : 16'sh7FFF)
		: snapped[15:0];

	assign hit_zero = (nv == zero);
	assign elapsed  = item.now_ms - start_q[slot_sel];
	assign expired  = elapsed > {16'd0, cfg.hold_ms};

	assign result.new_value = nv;
	assign result.accepted  = hit_zero || !active_q[slot_sel] || expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KNOBS; k++) begin
				last_q[k] <= 32'd0;
			end
			for (int s = 0; s < NUM_HOLD_SLOTS; s++) begin
				start_q[s] <= 32'd0;
			end
			active_q <= '0;
		end else if (fire) begin
			last_q[knob_sel] <= item.now_ms;
			if (hit_zero) begin
				start_q[slot_sel]  <= item.now_ms;
				active_q[slot_sel] <= 1'b1;
			end else if (active_q[slot_sel] && expired) begin
				active_q[slot_sel] <= 1'b0;
			end
		end
	end

	`KSA_ASSERT(a_hold_starts, (fire && hit_zero) |=> active_q[$past(slot_sel)], "no hold")
	`KSA_ASSERT(a_free_slot_accepts, !active_q[slot_sel] |-> result.accepted, "idle refused")
	`KSA_ASSERT(a_timer_updated, fire |=> (last_q[$past(knob_sel)] == $past(item.now_ms)), "timer")

endmodule
`default_nettype wire

// ===== src/knob_step_accelerator_zero_detent_unit.sv =====
// Knob step accelerator with zero detent: one knob event in, one proposed value and accept
// flag out. A word is taken every cycle while the output is not stalled; its result passes
// through the input register, then the result register. A stalled output holds one result and
// one event in flight.
// The rate is set by the read-modify-write of the per-knob event timers and the
// per-slot hold timers, which lets an event see the state left by the one just before it.
`timescale 1ns / 1ps
`default_nettype none
`include "knob_step_accelerator_zero_detent_unit_macros.svh"
module knob_step_accelerator_zero_detent_unit
	import ksa_pkg::*;
#(
	parameter int NUM_KNOBS      = NUM_KNOBS_DEF,
	parameter int NUM_HOLD_SLOTS = NUM_HOLD_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	ksa_evt_if.sink                evt,
	ksa_res_if.source              res
);

	ksa_cfg_t    cfg;
	ksa_item_t   item_s1;
	logic        valid_s1;
	ksa_result_t core_res;
	ksa_result_t res_s2;
	logic        valid_s2;
	logic        adv;
	logic        take;

	ksa_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The event stage moves on whenever the result register is empty or being drained.
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || adv;
	assign take      = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.knob_index    <= evt.knob_index;
			item_s1.hold_slot     <= evt.hold_slot;
			item_s1.zero_select   <= evt.zero_select;
			item_s1.rel_step      <= evt.rel_step;
			item_s1.current_value <= evt.current_value;
			item_s1.now_ms        <= evt.now_ms;
		end
	end

	ksa_step_core #(
		.NUM_KNOBS      (NUM_KNOBS),
		.NUM_HOLD_SLOTS (NUM_HOLD_SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (adv),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= core_res;
		end
	end

	assign res.valid     = valid_s2;
	assign res.new_value = res_s2.new_value;
	assign res.accepted  = res_s2.accepted;

	`KSA_ASSERT(a_adv_fills_out, adv |=> valid_s2, "advanced word lost")
	`KSA_ASSERT(a_stall_cause, !evt.ready |-> (valid_s1 && valid_s2 && !res.ready), "bad stall")
	`KSA_ASSERT_RST(a_reset_empty, !arst_n |-> (!valid_s1 && !valid_s2), "not empty in reset")

endmodule
`default_nettype wire
